>>> hw/rtl/ilrp_pkg.sv
// shared types, constants and character helpers for the integer literal radix parser
package ilrp_pkg;

	localparam int unsigned CHAR_W    = 8;
	localparam int unsigned VALUE_W   = 32;
	localparam int unsigned ACCUM_W   = 64;
	// room for accum * 16 + 15 with accum at most 2^(ACCUM_W-1)
	localparam int unsigned ACC_EXT_W = ACCUM_W + 4;
	localparam int unsigned NUM_LANES = 3;
	localparam int unsigned LEAD_N    = 3;

	localparam logic [ACC_EXT_W-1:0] ACC_LIM = ACC_EXT_W'(1) << (ACCUM_W - 1);
	localparam logic [VALUE_W-1:0] SAT_POS = VALUE_W'(ACC_LIM - ACC_EXT_W'(1));
	localparam logic [VALUE_W-1:0] SAT_NEG = VALUE_W'(~ACC_LIM + ACC_EXT_W'(1));

	// result classes
	typedef enum logic [2:0] {
		CLS_DEC = 3'd0,
		CLS_HEX = 3'd1,
		CLS_OCT = 3'd2,
		CLS_BIN = 3'd3,
		CLS_BAD = 3'd4
	} radix_class_t;

	// scan phases
	typedef enum logic [2:0] {
		PH_LEAD  = 3'd0,
		PH_FIRST = 3'd1,
		PH_ZERO  = 3'd2,
		PH_OTHER = 3'd3,
		PH_ZEROX = 3'd4,
		PH_ZEROO = 3'd5
	} phase_t;

	// accumulator lanes
	typedef logic [1:0] lane_t;
	localparam lane_t LANE_HEX = 2'd0;
	localparam lane_t LANE_OCT = 2'd1;
	localparam lane_t LANE_DEC = 2'd2;
	localparam logic [NUM_LANES-1:0][4:0] LANE_BASE = {5'd10, 5'd8, 5'd16};

	localparam logic [4:0] DIG_NONE = 5'd16;

	// character codes
	localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
	localparam logic [CHAR_W-1:0] CH_1     = 8'h31;
	localparam logic [CHAR_W-1:0] CH_7     = 8'h37;
	localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
	localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
	localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
	localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
	localparam logic [CHAR_W-1:0] CH_LB    = 8'h62;
	localparam logic [CHAR_W-1:0] CH_UB    = 8'h42;
	localparam logic [CHAR_W-1:0] CH_LL    = 8'h6C;
	localparam logic [CHAR_W-1:0] CH_UL    = 8'h4C;
	localparam logic [CHAR_W-1:0] CH_LU    = 8'h75;
	localparam logic [CHAR_W-1:0] CH_UU    = 8'h55;

	// scan state carried between characters
	typedef struct packed {
		logic [1:0]                    cnt;
		logic [LEAD_N-1:0][CHAR_W-1:0] lead;
		logic                          bad;
		phase_t                        phase;
		logic                          neg;
		logic [VALUE_W-1:0]            bin_cur;
		logic [VALUE_W-1:0]            bin_prev;
	} scan_t;

	// accumulator control from the scanner
	typedef struct packed {
		logic en;
		logic skip_x;
	} feed_t;

	function automatic logic is_dig(input logic [CHAR_W-1:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic is_xx(input logic [CHAR_W-1:0] c);
		return (c == CH_LX) || (c == CH_UX);
	endfunction

	function automatic logic is_bb(input logic [CHAR_W-1:0] c);
		return (c == CH_LB) || (c == CH_UB);
	endfunction

	// digit value 0..15, or DIG_NONE outside the hex digits
	function automatic logic [4:0] dig_code(input logic [CHAR_W-1:0] c);
		logic [4:0] r;
		r = DIG_NONE;
		if (is_dig(c)) begin
			r = 5'(c - CH_0);
		end else if ((c >= CH_LA) && (c <= CH_LF)) begin
			r = 5'(c - CH_LA) + 5'd10;
		end else if ((c >= CH_UA) && (c <= CH_UF)) begin
			r = 5'(c - CH_UA) + 5'd10;
		end
		return r;
	endfunction

	function automatic logic is_allowed(input logic [CHAR_W-1:0] c);
		return (dig_code(c) != DIG_NONE) || (c == CH_LL) || (c == CH_UL) ||
			(c == CH_LU) || (c == CH_UU) || is_xx(c) || is_bb(c);
	endfunction

	function automatic logic is_space(input logic [CHAR_W-1:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic is_sign_pair(input logic [CHAR_W-1:0] a,
		input logic [CHAR_W-1:0] b);
		return ((a == CH_MINUS) || (a == CH_PLUS)) && (is_dig(b) || (b == CH_DOT));
	endfunction

endpackage

>>> hw/rtl/ilrp_if.sv
// valid/ready channels for characters in and parse results out
interface ilrp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       last_char;

	modport source (output valid, output char_in, output last_char, input ready);
	modport sink (input valid, input char_in, input last_char, output ready);
endinterface

interface ilrp_result_if;
	logic              valid;
	logic              ready;
	logic signed [31:0] value;
	logic [2:0]        radix_class;
	logic              saturated;

	modport source (output valid, output value, output radix_class, output saturated,
		input ready);
	modport sink (input valid, input value, input radix_class, input saturated,
		output ready);
endinterface

>>> hw/rtl/ilrp_scan.sv
// scanner: leading characters, sign, prefix phase, bad character flag and binary sums
module ilrp_scan import ilrp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              step_last,
	input  logic [CHAR_W-1:0] ch,
	output scan_t             nxt,
	output feed_t             feed
);

	scan_t cur_q;

	// next scan state for this character
	always_comb begin
		nxt = cur_q;
		if (cur_q.cnt != 2'd3) begin
			nxt.lead[cur_q.cnt] = ch;
			nxt.cnt = cur_q.cnt + 2'd1;
		end
		if ((cur_q.cnt != 2'd0) && !is_allowed(ch)) begin
			nxt.bad = 1'b1;
		end
		nxt.bin_prev = cur_q.bin_cur;
		nxt.bin_cur = is_bb(ch) ? '0 : {cur_q.bin_cur[VALUE_W-2:0], ch == CH_1};
		case (cur_q.phase)
			PH_LEAD: begin
				if ((ch == CH_PLUS) || (ch == CH_MINUS)) begin
					nxt.neg = (ch == CH_MINUS);
					nxt.phase = PH_FIRST;
				end else if (!is_space(ch)) begin
					nxt.phase = (ch == CH_0) ? PH_ZERO : PH_OTHER;
				end
			end
			PH_FIRST: begin
				nxt.phase = (ch == CH_0) ? PH_ZERO : PH_OTHER;
			end
			PH_ZERO: begin
				nxt.phase = is_xx(ch) ? PH_ZEROX : PH_ZEROO;
			end
			default: begin
				nxt.phase = cur_q.phase;
			end
		endcase
	end

	// digits reach the accumulators once whitespace and sign are behind us
	always_comb begin
		feed.en = (cur_q.phase != PH_LEAD) ||
			(!is_space(ch) && (ch != CH_PLUS) && (ch != CH_MINUS));
		feed.skip_x = (cur_q.phase == PH_ZERO) && is_xx(ch);
	end

	// state register, cleared after the final character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (step) begin
			cur_q <= step_last ? '0 : nxt;
		end
	end

`ifndef NO_ASSERTIONS
	a_scan_clear: assert property (@(posedge clk) disable iff (!arst_n)
		step && step_last |=> (cur_q.cnt == 2'd0) && (cur_q.phase == PH_LEAD) && !cur_q.bad)
		else $error("scan state not cleared after final character");
`endif

endmodule

>>> hw/rtl/ilrp_accum.sv
// three strtol-style accumulators, one per base, with overflow and stop flags
module ilrp_accum import ilrp_pkg::*; (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  logic                              step_last,
	input  logic [CHAR_W-1:0]                 ch,
	input  feed_t                             feed,
	output logic [NUM_LANES-1:0][ACCUM_W-1:0] acc_nxt,
	output logic [NUM_LANES-1:0]              ovf_nxt
);

	logic [NUM_LANES-1:0][ACCUM_W-1:0] acc_q;
	logic [NUM_LANES-1:0]              ovf_q;
	logic [NUM_LANES-1:0]              done_q;
	logic [NUM_LANES-1:0]              done_nxt;
	logic [4:0]                        dcode;

	assign dcode = dig_code(ch);

	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		logic [ACC_EXT_W-1:0] ext;
		logic [ACC_EXT_W-1:0] scaled;
		logic [ACC_EXT_W-1:0] sum;
		logic                 in_range;
		logic                 over;
		logic                 skip;
		logic [ACCUM_W-1:0]   acc_n;
		logic                 ovf_n;
		logic                 done_n;

		assign ext = ACC_EXT_W'(acc_q[g]);

		// multiply by the lane base
		if (g == LANE_DEC) begin : g_dec
			assign scaled = (ext << 3) + (ext << 1);
		end else if (g == LANE_OCT) begin : g_oct
			assign scaled = ext << 3;
		end else begin : g_hex
			assign scaled = ext << 4;
		end

		assign sum = scaled + ACC_EXT_W'(dcode[3:0]);
		assign in_range = dcode < LANE_BASE[g];
		assign over = sum > ACC_LIM;
		assign skip = (lane_t'(g) == LANE_HEX) && feed.skip_x;

		// one strtol digit step
		always_comb begin
			acc_n = acc_q[g];
			ovf_n = ovf_q[g];
			done_n = done_q[g];
			if (feed.en && !done_q[g] && !skip) begin
				if (!in_range) begin
					done_n = 1'b1;
				end else if (!ovf_q[g]) begin
					if (over) begin
						ovf_n = 1'b1;
					end else begin
						acc_n = sum[ACCUM_W-1:0];
					end
				end
			end
		end

		assign acc_nxt[g] = acc_n;
		assign ovf_nxt[g] = ovf_n;
		assign done_nxt[g] = done_n;
	end

	// accumulator registers, cleared after the final character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			ovf_q <= '0;
			done_q <= '0;
		end else if (step) begin
			if (step_last) begin
				acc_q <= '0;
				ovf_q <= '0;
				done_q <= '0;
			end else begin
				acc_q <= acc_nxt;
				ovf_q <= ovf_nxt;
				done_q <= done_nxt;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		step && step_last |=> (acc_q == '0) && (ovf_q == '0) && (done_q == '0))
		else $error("accumulators not cleared after final character");
`endif

endmodule

>>> hw/rtl/ilrp_result.sv
// classification, value selection with saturation, and the result register
module ilrp_result import ilrp_pkg::*; (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              fin,
	input  logic [CHAR_W-1:0]                 ch,
	input  scan_t                             nxt,
	input  logic [NUM_LANES-1:0][ACCUM_W-1:0] acc_nxt,
	input  logic [NUM_LANES-1:0]              ovf_nxt,
	output logic                              out_free,
	ilrp_result_if.source                     res
);

	radix_class_t       cls;
	logic               pfx_bin;
	lane_t              sel;
	logic [ACCUM_W-1:0] acc_sel;
	logic               sat;
	logic [VALUE_W-1:0] value_d;
	logic [CHAR_W-1:0]  c0;
	logic [CHAR_W-1:0]  c1;
	logic [CHAR_W-1:0]  c2;

	logic               valid_q;
	logic [VALUE_W-1:0] value_q;
	radix_class_t       cls_q;
	logic               sat_q;

	assign c0 = nxt.lead[0];
	assign c1 = nxt.lead[1];
	assign c2 = nxt.lead[2];

	// classify from the leading characters and the final one
	always_comb begin
		cls = CLS_DEC;
		pfx_bin = 1'b0;
		if (nxt.cnt == 2'd1) begin
			cls = is_dig(c0) ? CLS_DEC : CLS_BAD;
		end else if (nxt.bad) begin
			cls = CLS_BAD;
		end else if (!is_sign_pair(c0, c1)) begin
			if (!is_allowed(c0)) begin
				cls = CLS_BAD;
			end else if (c0 == CH_0) begin
				if (is_xx(c1)) begin
					cls = CLS_HEX;
				end else if (is_bb(c1)) begin
					cls = CLS_BIN;
					pfx_bin = 1'b1;
				end else if ((c1 >= CH_0) && (c1 <= CH_7)) begin
					cls = CLS_OCT;
				end else begin
					cls = CLS_DEC;
				end
			end else begin
				cls = is_bb(ch) ? CLS_BIN : CLS_DEC;
			end
		end else if (nxt.cnt != 2'd3) begin
			cls = CLS_DEC;
		end else if (c1 == CH_0) begin
			if (is_xx(c2)) begin
				cls = CLS_HEX;
			end else if ((c2 >= CH_0) && (c2 <= CH_7)) begin
				cls = CLS_OCT;
			end else begin
				cls = CLS_DEC;
			end
		end else begin
			cls = is_bb(ch) ? CLS_BIN : CLS_DEC;
		end
	end

	// accumulator lane behind the class, base detection for invalid literals
	always_comb begin
		case (cls)
			CLS_HEX: sel = LANE_HEX;
			CLS_OCT: sel = LANE_OCT;
			CLS_DEC: sel = LANE_DEC;
			CLS_BIN: sel = LANE_DEC;
			default: begin
				if (nxt.phase == PH_ZEROX) begin
					sel = LANE_HEX;
				end else if (nxt.phase == PH_OTHER) begin
					sel = LANE_DEC;
				end else begin
					sel = LANE_OCT;
				end
			end
		endcase
	end

	// value with sign and saturation, binary literals unsigned and unsaturated, low word only
	always_comb begin
		acc_sel = acc_nxt[sel];
		sat = 1'b0;
		if (cls == CLS_BIN) begin
			value_d = pfx_bin ? nxt.bin_cur : nxt.bin_prev;
		end else begin
			sat = ovf_nxt[sel] || (!nxt.neg && acc_sel[ACCUM_W-1]);
			if (sat) begin
				value_d = nxt.neg ? SAT_NEG : SAT_POS;
			end else begin
				value_d = nxt.neg ? -acc_sel[VALUE_W-1:0] : acc_sel[VALUE_W-1:0];
			end
		end
	end

	assign out_free = !valid_q || res.ready;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (fin) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			value_q <= value_d;
			cls_q <= cls;
			sat_q <= sat;
		end
	end

	assign res.valid = valid_q;
	assign res.value = value_q;
	assign res.radix_class = cls_q;
	assign res.saturated = sat_q;

`ifndef NO_ASSERTIONS
	a_bin_unsat: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && (cls_q == CLS_BIN) |-> !sat_q)
		else $error("binary result flagged as saturated");
`endif

endmodule

>>> hw/rtl/integer_literal_radix_parser_unit.sv
// Integer literal radix parser: characters of a literal in, one classified value out
//
// lit carries one character per request with last_char marking the end of a
// literal; res carries one result per literal: the low 32 bits of the value,
// the radix class and the saturation flag.
// A final character is registered in the input register, processed into the
// result register once that register is free, and its result is offered
// from then on.
// Throughput: one character per cycle; the multiply by the base and the add of
// each digit accumulator complete between the input and state registers.
// A final character waits in the input register only while the result
// register still holds an untaken result; other characters never wait.
// Reset clears the input stage, the scan state, the accumulators and the
// result valid flag; the first character after reset starts a new literal.
// All scan state returns to its reset value after each final character.
module integer_literal_radix_parser_unit import ilrp_pkg::*; (
	input logic           clk,
	input logic           arst_n,
	ilrp_char_if.sink     lit,
	ilrp_result_if.source res
);

	logic                              valid_s1;
	logic [CHAR_W-1:0]                 char_s1;
	logic                              last_s1;
	logic                              s1_go;
	logic                              s1_fin;
	logic                              out_free;
	scan_t                             scan_nxt;
	feed_t                             feed;
	logic [NUM_LANES-1:0][ACCUM_W-1:0] acc_nxt;
	logic [NUM_LANES-1:0]              ovf_nxt;

	// the stage moves unless a final character meets an untaken result in the result register
	assign s1_go = valid_s1 && (!last_s1 || out_free);
	assign s1_fin = s1_go && last_s1;
	assign lit.ready = !valid_s1 || s1_go;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (lit.valid && lit.ready) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (lit.valid && lit.ready) begin
			char_s1 <= lit.char_in;
			last_s1 <= lit.last_char;
		end
	end

	ilrp_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (s1_go),
		.step_last (last_s1),
		.ch        (char_s1),
		.nxt       (scan_nxt),
		.feed      (feed)
	);

	ilrp_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (s1_go),
		.step_last (last_s1),
		.ch        (char_s1),
		.feed      (feed),
		.acc_nxt   (acc_nxt),
		.ovf_nxt   (ovf_nxt)
	);

	ilrp_result u_result (
		.clk      (clk),
		.arst_n   (arst_n),
		.fin      (s1_fin),
		.ch       (char_s1),
		.nxt      (scan_nxt),
		.acc_nxt  (acc_nxt),
		.ovf_nxt  (ovf_nxt),
		.out_free (out_free),
		.res      (res)
	);

`ifndef NO_ASSERTIONS
	a_fin_shows: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fin |=> res.valid)
		else $error("final character processed but no result offered");
	a_mid_flows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !last_s1 |-> lit.ready)
		else $error("intake stalled behind a non-final character");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.ready && !s1_fin |=> !res.valid)
		else $error("result offered twice");
`endif

endmodule
